FILE: sv/cdq_pkg.sv
// Shared types and codes for the circular deque core.
// Holds the request/response structs, command and status codes, and the cell control word.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;

	localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_POP_BACK   = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [2:0] CMD_LIST       = 3'd4;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] value_out;
		logic                     last;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   data;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/circular_deque_core.sv
// Push and pop requests: response in the cycle after acceptance; while responses are
// taken, one request per cycle. A list request holds the input until its last word is
// out, streaming one stored word per cycle unless stalled, rotated through the chain.
// Reset clears the valid bits of every cell, the occupancy and the sequencer at once;
// stored words are left as they are and no clearing pass is needed.
// Top level: cell chain plus sequencer; depends on cdq_pkg, cdq_cell and cdq_ctrl.
`default_nettype none

module circular_deque_core #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire cdq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output cdq_pkg::rsp_t      rsp
);

	logic [cdq_pkg::DATA_W-1:0] words [DEPTH];
	logic [DEPTH-1:0]           valids;
	logic [DEPTH-1:0]           backs;
	logic [cdq_pkg::DATA_W-1:0] back_word;
	cdq_pkg::cell_ctl_t         cell_ctl;

	// At most one cell flags itself as the back, so an OR of the gated words selects it.
	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | (words[i] & {cdq_pkg::DATA_W{backs[i]}});
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [cdq_pkg::DATA_W-1:0] prev_word, next_word;
		logic                      prev_valid, next_valid;

		if (g == 0) begin : g_first
			assign prev_word  = cell_ctl.data;
			assign prev_valid = 1'b1;
		end else begin : g_mid
			assign prev_word  = words[g-1];
			assign prev_valid = valids[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_word  = '0;
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_word  = words[g+1];
			assign next_valid = valids[g+1];
		end

		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.prev_word  (prev_word),
			.prev_valid (prev_valid),
			.next_word  (next_word),
			.next_valid (next_valid),
			.head_word  (words[0]),
			.word       (words[g]),
			.valid      (valids[g]),
			.back       (backs[g])
		);
	end

	cdq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.head_word (words[0]),
		.back_word (back_word),
		.cell_ctl  (cell_ctl)
	);

endmodule

`default_nettype wire

FILE: sv/cdq_cell.sv
// One storage cell of the deque chain: a word and its valid bit.
// Cell order is front to back; depends on cdq_pkg for the control word.
`default_nettype none

module cdq_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cdq_pkg::cell_ctl_t        ctl,
	input  wire logic [cdq_pkg::DATA_W-1:0] prev_word,
	input  wire logic                      prev_valid,
	input  wire logic [cdq_pkg::DATA_W-1:0] next_word,
	input  wire logic                      next_valid,
	input  wire logic [cdq_pkg::DATA_W-1:0] head_word,
	output logic      [cdq_pkg::DATA_W-1:0] word,
	output logic                           valid,
	output logic                           back
);

	logic [cdq_pkg::DATA_W-1:0] word_q;
	logic                      valid_q;

	assign word  = word_q;
	assign valid = valid_q;
	// The back word sits in the last valid cell of the chain.
	assign back  = valid_q & ~next_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				cdq_pkg::OP_PUSH_FRONT: valid_q <= prev_valid;
				cdq_pkg::OP_PUSH_BACK:  valid_q <= valid_q | prev_valid;
				cdq_pkg::OP_POP_FRONT:  valid_q <= next_valid;
				cdq_pkg::OP_POP_BACK:   valid_q <= valid_q & next_valid;
				default:                valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			cdq_pkg::OP_PUSH_FRONT: word_q <= prev_word;
			cdq_pkg::OP_PUSH_BACK: begin
				if (!valid_q && prev_valid) begin
					word_q <= ctl.data;
				end
			end
			cdq_pkg::OP_POP_FRONT: word_q <= next_word;
			cdq_pkg::OP_ROTATE: begin
				// Everything moves one place toward the front; the front word wraps to the back.
				if (valid_q) begin
					word_q <= back ? head_word : next_word;
				end
			end
			default: word_q <= word_q;
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/cdq_ctrl.sv
// Sequencer of the deque: occupancy count, list walk and the response register.
// Drives the cell chain through one control word; depends on cdq_pkg.
`default_nettype none

module cdq_ctrl #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire cdq_pkg::req_t              req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output cdq_pkg::rsp_t                   rsp,
	input  wire logic [cdq_pkg::DATA_W-1:0] head_word,
	input  wire logic [cdq_pkg::DATA_W-1:0] back_word,
	output cdq_pkg::cell_ctl_t              cell_ctl
);

	localparam int OCC_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LIST = 2'b10
	} state_t;

	state_t           state_q, state_d;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic [OCC_W-1:0] cnt_q, cnt_d;
	logic             rsp_valid_q;
	cdq_pkg::rsp_t    rsp_q, rsp_d;
	logic             out_free, accept, load;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) && out_free);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d       = state_q;
		occ_d         = occ_q;
		cnt_d         = cnt_q;
		load          = 1'b0;
		rsp_d         = rsp_q;
		cell_ctl.op   = cdq_pkg::OP_HOLD;
		cell_ctl.data = req.data_in;
		if (accept) begin
			rsp_d.status    = cdq_pkg::STS_OK;
			rsp_d.value_out = '0;
			rsp_d.last      = 1'b1;
			unique case (req.command)
				cdq_pkg::CMD_PUSH_BACK, cdq_pkg::CMD_PUSH_FRONT: begin
					load = 1'b1;
					if (occ_q == OCC_W'(DEPTH)) begin
						rsp_d.status = cdq_pkg::STS_FULL;
					end else begin
						occ_d       = occ_q + OCC_W'(1);
						cell_ctl.op = (req.command == cdq_pkg::CMD_PUSH_BACK) ?
							cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT;
					end
				end
				cdq_pkg::CMD_POP_BACK, cdq_pkg::CMD_POP_FRONT: begin
					load = 1'b1;
					if (occ_q == '0) begin
						rsp_d.status = cdq_pkg::STS_EMPTY;
					end else begin
						occ_d = occ_q - OCC_W'(1);
						if (req.command == cdq_pkg::CMD_POP_BACK) begin
							rsp_d.value_out = back_word;
							cell_ctl.op     = cdq_pkg::OP_POP_BACK;
						end else begin
							rsp_d.value_out = head_word;
							cell_ctl.op     = cdq_pkg::OP_POP_FRONT;
						end
					end
				end
				cdq_pkg::CMD_LIST: begin
					if (occ_q == '0) begin
						load         = 1'b1;
						rsp_d.status = cdq_pkg::STS_EMPTY;
					end else begin
						cnt_d   = occ_q;
						state_d = ST_LIST;
					end
				end
				default: begin
					// Unused command codes are dropped without a response.
				end
			endcase
		end else if (state_q == ST_LIST && out_free) begin
			load            = 1'b1;
			rsp_d.status    = cdq_pkg::STS_OK;
			rsp_d.value_out = head_word;
			rsp_d.last      = (cnt_q == OCC_W'(1));
			cell_ctl.op     = cdq_pkg::OP_ROTATE;
			cnt_d           = cnt_q - OCC_W'(1);
			if (cnt_q == OCC_W'(1)) begin
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			cnt_q   <= cnt_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/cdq_checker.sv
// Port-level checks of the circular deque core, attached by bind.
// Sees only the top-level ports; depends on cdq_pkg.
`default_nettype none

module cdq_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire cdq_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire cdq_pkg::rsp_t rsp
);

	// A stalled request stays offered with the same payload.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed");

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// No new request is taken while a response waits stalled.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request accepted over a stalled response");

	// Full and empty answers end their request and carry no word.
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != cdq_pkg::STS_OK |-> rsp.last && rsp.value_out == '0)
		else $error("full or empty response malformed");

	// While a list is still streaming, the input stays closed.
	a_list_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> req_stall)
		else $error("request accepted during a list");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);

`default_nettype wire

FILE: dv/circular_deque_checker.sv
`timescale 1ns / 1ps
// Watches the request and response channels of circular_deque_core and predicts every response.
// Holds its own ring of stored words and compares each taken response with the oldest expectation.
// Depends on cdq_pkg for the request/response structs and the command and status codes.

module circular_deque_checker #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  cdq_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  cdq_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending
);
	import cdq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	logic signed [DATA_W-1:0] ring_word [DEPTH];
	logic [IDX_W-1:0]         front_idx;
	logic [IDX_W-1:0]         back_idx;
	logic [IDX_W:0]           word_count;
	rsp_t                     expected_rsp [$];

	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
		return (i == DEPTH - 1) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
		return (i == 0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	function automatic void add_expected(input logic [1:0] status,
			input logic signed [DATA_W-1:0] value, input logic last);
		rsp_t r;
		r.status    = status;
		r.value_out = value;
		r.last      = last;
		expected_rsp.push_back(r);
	endfunction

	// Advances the deque model by one request and queues the responses it causes.
	function automatic void apply_command(input req_t r);
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] word;
		case (r.command)
		CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
			if (word_count == DEPTH) begin
				add_expected(STS_FULL, '0, 1'b1);
			end else begin
				if (r.command == CMD_PUSH_BACK) begin
					ring_word[back_idx] = r.data_in;
					back_idx = ring_inc(back_idx);
				end else begin
					front_idx = ring_dec(front_idx);
					ring_word[front_idx] = r.data_in;
				end
				word_count++;
				add_expected(STS_OK, '0, 1'b1);
			end
		end
		CMD_POP_BACK, CMD_POP_FRONT: begin
			if (word_count == 0) begin
				add_expected(STS_EMPTY, '0, 1'b1);
			end else begin
				if (r.command == CMD_POP_BACK) begin
					back_idx = ring_dec(back_idx);
					word = ring_word[back_idx];
				end else begin
					word = ring_word[front_idx];
					front_idx = ring_inc(front_idx);
				end
				word_count--;
				add_expected(STS_OK, word, 1'b1);
			end
		end
		CMD_LIST: begin
			if (word_count == 0) begin
				add_expected(STS_EMPTY, '0, 1'b1);
			end else begin
				idx = front_idx;
				for (int n = 0; n < word_count; n++) begin
					add_expected(STS_OK, ring_word[idx], n + 1 == word_count);
					idx = ring_inc(idx);
				end
			end
		end
		default: begin
			// Unused command codes are dropped without a response.
		end
		endcase
	endfunction

	task automatic check_response(input rsp_t got);
		rsp_t want;
		if (expected_rsp.size() == 0) begin
			$error("unexpected response: status %0d value_out %0d last %0d",
				got.status, got.value_out, got.last);
			fail_count++;
		end else begin
			want = expected_rsp.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				fail_count++;
			end
			if (got.value_out !== want.value_out) begin
				$error("value_out: expected %0d, actual %0d", want.value_out, got.value_out);
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_idx  = '0;
			back_idx   = '0;
			word_count = '0;
			fail_count = 0;
			expected_rsp.delete();
		end else begin
			// Compare before predicting, so a response cannot match a request taken at the same edge.
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
			if (req_valid && !req_stall)
				apply_command(req);
		end
		pending = expected_rsp.size();
	end

endmodule

FILE: dv/tb_circular_deque_core.sv
`timescale 1ns / 1ps
// Top of the circular_deque_core testbench: clock, reset, request stimulus and response stalls.
// Checking is done by circular_deque_checker; depends on cdq_pkg and the block itself.

module tb_circular_deque_core;
	import cdq_pkg::*;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	localparam int         DEPTH           = DEPTH_DEF;
	localparam int         RANDOM_REQUESTS = 380;
	localparam int         QUIET_TAIL      = 60;
	localparam int         HOLD_CYCLES     = 300;
	localparam int         WATCHDOG_LIMIT  = 3000;
	localparam int         DRAIN_CYCLES    = 40;
	localparam logic [2:0] CMD_MAX         = '1;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	int   idle_cycles = 0;
	bit   quiet       = 1'b0;
	bit   hold_rsp    = 1'b0;

	always #4 clk = ~clk;

	circular_deque_core #(.DEPTH(DEPTH)) i_dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	circular_deque_checker #(.DEPTH(DEPTH)) i_checker (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.fail_count,
		.pending
	);

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 11))
		0: return {1'b0, {(DATA_W-1){1'b1}}};
		1: return {1'b1, {(DATA_W-1){1'b0}}};
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] random_push();
		return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
	endfunction

	function automatic logic [2:0] random_command(input traffic_mode_t mode);
		int roll;
		int push_share;
		roll = $urandom_range(0, 99);
		push_share = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 15 : 45;
		if (roll < push_share)
			return random_push();
		if (roll < push_share + 10)
			return CMD_LIST;
		return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
	endfunction

	// Offers one request, after an optional idle burst, and returns at the edge that takes it.
	task automatic send_request(input logic [2:0] cmd, input logic [DATA_W-1:0] word);
		int gap;
		gap = (!quiet && $urandom_range(0, 6) == 0) ? $urandom_range(1, 15) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{command: cmd, data_in: word};
		do @(posedge clk); while (req_stall);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_rsp = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		traffic_mode_t mode;
		int            sent;
		bit            hold_started;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty deque: list and both pops report empty, unused codes are dropped.
		send_request(CMD_LIST, random_word());
		send_request(CMD_POP_BACK, random_word());
		send_request(CMD_POP_FRONT, random_word());
		for (int c = CMD_LIST + 1; c <= CMD_MAX; c++)
			send_request(3'(c), random_word());

		// Extreme words through both ends.
		send_request(CMD_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
		send_request(CMD_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
		send_request(CMD_PUSH_BACK, '0);
		send_request(CMD_PUSH_FRONT, '1);
		send_request(CMD_LIST, random_word());
		send_request(CMD_POP_FRONT, random_word());
		send_request(CMD_POP_BACK, random_word());

		// Fill up, hit the full answer from both ends, and list a full ring.
		repeat (DEPTH - 2)
			send_request(random_push(), random_word());
		send_request(CMD_PUSH_BACK, random_word());
		send_request(CMD_PUSH_FRONT, random_word());
		send_request(CMD_LIST, random_word());

		sent = 0;
		hold_started = 1'b0;
		mode = MODE_DRAIN;
		while (sent < RANDOM_REQUESTS) begin
			if (sent % 30 == 0)
				mode = traffic_mode_t'($urandom_range(0, 2));
			if (sent == RANDOM_REQUESTS / 2 && !hold_started) begin
				hold_started = 1'b1;
				hold_rsp = 1'b1;
				mode = MODE_FILL;
			end
			if (sent >= RANDOM_REQUESTS - QUIET_TAIL)
				quiet = 1'b1;
			if ($urandom_range(0, 24) == 0) begin
				send_request(3'($urandom_range(CMD_LIST + 1, CMD_MAX)), random_word());
			end else begin
				send_request(random_command(mode), random_word());
				sent++;
			end
		end
		req_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
